### src/flph_pkg.sv
package flph_pkg;

  localparam int unsigned BinCountDefault    = 8;
  localparam int unsigned CounterBitsDefault = 32;

  // Bin 0 covers values up to 2**(FirstBinLog + 1).
  localparam int unsigned FirstBinLog = 3;

  // Wide enough for any bin count the block supports.
  localparam int unsigned BinIdxW = 5;

  localparam int unsigned LenW    = 16;
  localparam int unsigned TsW     = 63;
  localparam int unsigned GapW    = 32;
  localparam int unsigned RdBinW  = 3;
  localparam int unsigned RdIdxW  = 5;
  localparam int unsigned OpW     = 2;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutCntW  = 32;
  localparam int unsigned OutBinW  = 3;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-3:0] RegCountEmpty = '0;

  typedef enum logic [1:0] {
    KindNone,
    KindStart,
    KindPacket,
    KindRead
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 dir;
    logic                 acct;
    logic [BinIdxW-1:0]   size_bin;
    logic [TsW-1:0]       ts;
    logic                 rd_gap;
    logic                 rd_dir;
    logic [RdBinW-1:0]    rd_bin;
    logic                 rd_ok;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Log2 bin of a value: highest set bit of (v - 1), clamped to the bin range.
  function automatic logic [BinIdxW-1:0] bin_of(input logic [GapW-1:0] v,
                                                input int unsigned bin_count);
    logic [GapW-1:0] vm;
    int unsigned     lg;
    int unsigned     hi;
    vm = v - 1'b1;
    lg = 0;
    hi = bin_count + FirstBinLog - 1;
    if (v > 1) begin
      for (int i = 0; i < GapW; i++) begin
        if (vm[i]) begin
          lg = i;
        end
      end
    end
    if (lg < FirstBinLog) begin
      lg = FirstBinLog;
    end
    if (lg > hi) begin
      lg = hi;
    end
    return BinIdxW'(lg - FirstBinLog);
  endfunction

endpackage

### src/flow_log2_packet_histogram_unit.sv
// Channel   Dir  Payload                                               Handshake
// s_axis    in   tuser: operation; tdata: dir, valid, length, time, idx  tvalid/tready
// m_axis    out  tdata: counted, size bin, gap counted, gap bin, value   tvalid/tready
// apb       in   count_empty_packets at address 0                      psel/penable
//
// One word is taken and one result given per clock when neither side stalls.
// A taken word moves through the queue, where the gap subtract is done, a stage
// for the gap bin and the counter memory read, and a stage for the counter
// update into the output register.
// Reset clears the counters at once through per-entry valid bits; no sweep is needed.
// The two-word queue drops s_axis_tready only when full, so the input side keeps
// flowing while a result waits on m_axis.
module flow_log2_packet_histogram_unit #(
  parameter int unsigned BIN_COUNT    = flph_pkg::BinCountDefault,
  parameter int unsigned COUNTER_BITS = flph_pkg::CounterBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] direction, [1] payload_valid, [17:2] payload_length,
  // [80:18] timestamp_ns, [85:81] read_index, [87:86] zero
  input  logic [flph_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [flph_pkg::OpW-1:0]       s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] packet_counted, [3:1] size_bin, [4] gap_counted, [7:5] gap_bin,
  // [39:8] counter_value
  output logic [flph_pkg::OutDataW-1:0]  m_axis_tdata,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [flph_pkg::ApbAddrW-1:0]  paddr,
  input  logic [flph_pkg::ApbDataW-1:0]  pwdata,
  output logic [flph_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  logic                  count_empty_q;
  logic                  reg_hit;
  logic                  push, pop;
  flph_pkg::item_t       fe_item, q_item;
  flph_pkg::q_stat_t     q_stat;

  assign reg_hit = (paddr[flph_pkg::ApbAddrW-1:2] == flph_pkg::RegCountEmpty);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(flph_pkg::ApbDataW - 1){1'b0}}, count_empty_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_empty_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      count_empty_q <= pwdata[0];
    end
  end

  flph_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_o    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .count_empty_i (count_empty_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .item_o        (fe_item)
  );

  flph_fifo #(
    .WIDTH ($bits(flph_pkg::item_t)),
    .DEPTH (flph_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fe_item),
    .pop_i   (pop),
    .rdata_o (q_item),
    .stat_o  (q_stat)
  );

  flph_back #(
    .BIN_COUNT    (BIN_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

  // A word taken on the input must be waiting in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !q_stat.empty)
    else $error("accepted word missing from queue");

  // A gap is only ever binned together with its packet's size.
  a_gap_needs_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0])
    else $error("gap counted without packet counted");

  // Only a read returns a counter value, and a read never counts anything.
  a_read_counts_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[39:8] != '0) |-> !m_axis_tdata[0] && !m_axis_tdata[4])
    else $error("counter value on an updating word");

endmodule

### src/flph_fifo.sv
module flph_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = flph_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output flph_pkg::q_stat_t   stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));

endmodule

### src/flph_front.sv
module flph_front #(
  parameter int unsigned BIN_COUNT = flph_pkg::BinCountDefault
) (
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [flph_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [flph_pkg::OpW-1:0]      s_tuser_i,
  input  logic                          count_empty_i,
  input  flph_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output flph_pkg::item_t               item_o
);

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpPacket = 2'd1,
    OpRead   = 2'd2
  } op_e;

  localparam int unsigned DirBit   = 0;
  localparam int unsigned ValidBit = 1;
  localparam int unsigned LenLsb   = 2;
  localparam int unsigned TsLsb    = LenLsb + flph_pkg::LenW;
  localparam int unsigned RidxLsb  = TsLsb + flph_pkg::TsW;

  flph_pkg::kind_e                kind;
  logic                           pay_valid;
  logic [flph_pkg::LenW-1:0]      len;
  logic [flph_pkg::RdIdxW-1:0]    ridx;
  logic                           counts;

  assign pay_valid = s_tdata_i[ValidBit];
  assign len       = s_tdata_i[LenLsb +: flph_pkg::LenW];
  assign ridx      = s_tdata_i[RidxLsb +: flph_pkg::RdIdxW];

  always_comb begin
    unique case (op_e'(s_tuser_i))
      OpStart:  kind = flph_pkg::KindStart;
      OpPacket: kind = flph_pkg::KindPacket;
      OpRead:   kind = flph_pkg::KindRead;
      default:  kind = flph_pkg::KindNone;
    endcase
  end

  assign counts = (kind == flph_pkg::KindStart || kind == flph_pkg::KindPacket) &&
                  pay_valid && (len != '0 || count_empty_i);

  always_comb begin
    item_o.kind     = kind;
    // A new flow always opens in the forward direction.
    item_o.dir      = (kind == flph_pkg::KindStart) ? 1'b0 : s_tdata_i[DirBit];
    item_o.acct     = counts;
    item_o.size_bin = flph_pkg::bin_of(
                        {{(flph_pkg::GapW - flph_pkg::LenW){1'b0}}, len}, BIN_COUNT);
    item_o.ts       = s_tdata_i[TsLsb +: flph_pkg::TsW];
    item_o.rd_gap   = ridx[flph_pkg::RdIdxW-1];
    item_o.rd_dir   = ridx[flph_pkg::RdBinW];
    item_o.rd_bin   = ridx[flph_pkg::RdBinW-1:0];
    item_o.rd_ok    = (ridx[flph_pkg::RdBinW-1:0] < BIN_COUNT);
  end

  assign s_tready_o = !q_stat_i.full;
  assign push_o     = s_tvalid_i && !q_stat_i.full;

endmodule

### src/flph_back.sv
module flph_back #(
  parameter int unsigned BIN_COUNT    = flph_pkg::BinCountDefault,
  parameter int unsigned COUNTER_BITS = flph_pkg::CounterBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  flph_pkg::q_stat_t              q_stat_i,
  input  flph_pkg::item_t                q_item_i,
  output logic                           pop_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [flph_pkg::OutDataW-1:0]  m_tdata_o
);

  localparam int unsigned BinW  = $clog2(BIN_COUNT);
  localparam int unsigned AddrW = BinW + 1;
  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned TsW   = flph_pkg::TsW;
  localparam int unsigned GapW  = flph_pkg::GapW;

  // Arrival state, used when a word leaves the queue.
  logic [1:0]             seen_q, seen_d;
  logic [TsW-1:0]         last_q [2];
  logic [TsW-1:0]         last_d [2];

  // Stage one: gap worked out, counter reads not yet issued.
  logic                   s1_vld_q;
  flph_pkg::item_t        s1_item_q;
  logic                   s1_gcnt_q;
  logic [GapW-1:0]        s1_gap_q;

  // Stage two: counter read data available, update and result.
  logic                   s2_vld_q;
  flph_pkg::kind_e        s2_kind_q;
  logic                   s2_acct_q;
  logic                   s2_gcnt_q;
  logic [AddrW-1:0]       s2_sz_addr_q;
  logic [AddrW-1:0]       s2_gp_addr_q;
  logic                   s2_rd_gap_q;
  logic                   s2_rd_ok_q;

  logic [COUNTER_BITS-1:0] sz_mem [Depth];
  logic [COUNTER_BITS-1:0] gp_mem [Depth];
  logic [Depth-1:0]        sz_ok_q;
  logic [Depth-1:0]        gp_ok_q;
  logic [COUNTER_BITS-1:0] sz_rdata_q, gp_rdata_q;
  logic                    sz_rok_q, gp_rok_q;
  logic                    sz_byp_q, gp_byp_q;
  logic [COUNTER_BITS-1:0] sz_bdata_q, gp_bdata_q;

  logic                    out_vld_q;
  logic [flph_pkg::OutDataW-1:0] out_data_q;

  logic                    out_free, s2_adv, s2_free, s1_adv, s1_free, pop;
  logic [TsW-1:0]          last_sel, gap_diff;
  logic [GapW-1:0]         gap_a;
  logic                    gcnt_a;
  logic [flph_pkg::BinIdxW-1:0] gbin_full;
  logic [AddrW-1:0]        rd_addr, sz_raddr, gp_raddr;
  logic [COUNTER_BITS-1:0] sz_base, gp_base, sz_new, gp_new, rd_val;
  logic [flph_pkg::OutCntW-1:0] cnt_out;
  logic [flph_pkg::OutBinW-1:0] sbin_out, gbin_out;

  assign out_free = !out_vld_q || m_tready_i;
  assign s2_adv   = s2_vld_q && out_free;
  assign s2_free  = !s2_vld_q || out_free;
  assign s1_adv   = s1_vld_q && s2_free;
  assign s1_free  = !s1_vld_q || s2_free;
  assign pop      = !q_stat_i.empty && s1_free;
  assign pop_o    = pop;

  // Gap since the previous counted packet of the same direction.
  assign last_sel = last_q[q_item_i.dir];
  assign gap_diff = q_item_i.ts - last_sel;
  assign gap_a    = (q_item_i.ts >= last_sel) ? gap_diff[GapW-1:0] : '0;
  assign gcnt_a   = q_item_i.acct && (q_item_i.kind != flph_pkg::KindStart) &&
                    seen_q[q_item_i.dir];

  always_comb begin
    seen_d    = seen_q;
    last_d[0] = last_q[0];
    last_d[1] = last_q[1];
    if (pop) begin
      if (q_item_i.kind == flph_pkg::KindStart) begin
        seen_d    = '0;
        last_d[0] = '0;
        last_d[1] = '0;
      end
      if (q_item_i.acct) begin
        seen_d[q_item_i.dir] = 1'b1;
        last_d[q_item_i.dir] = q_item_i.ts;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      last_q[0] <= '0;
      last_q[1] <= '0;
    end else begin
      seen_q    <= seen_d;
      last_q[0] <= last_d[0];
      last_q[1] <= last_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (pop) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q <= q_item_i;
      s1_gcnt_q <= gcnt_a;
      s1_gap_q  <= gap_a;
    end
  end

  // Counter addresses: a read takes its own index, an update the chosen bins.
  assign gbin_full = flph_pkg::bin_of(s1_gap_q, BIN_COUNT);
  assign rd_addr   = {s1_item_q.rd_dir, BinW'(s1_item_q.rd_bin)};
  assign sz_raddr  = (s1_item_q.kind == flph_pkg::KindRead) ? rd_addr :
                     {s1_item_q.dir, s1_item_q.size_bin[BinW-1:0]};
  assign gp_raddr  = (s1_item_q.kind == flph_pkg::KindRead) ? rd_addr :
                     {s1_item_q.dir, gbin_full[BinW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_kind_q <= flph_pkg::KindNone;
      s2_acct_q <= 1'b0;
      s2_gcnt_q <= 1'b0;
      sz_byp_q  <= 1'b0;
      gp_byp_q  <= 1'b0;
    end else if (s1_adv) begin
      s2_vld_q  <= 1'b1;
      s2_kind_q <= s1_item_q.kind;
      s2_acct_q <= s1_item_q.acct;
      s2_gcnt_q <= s1_gcnt_q;
      // The word ahead writes back on this same edge, so take its value directly.
      sz_byp_q  <= s2_adv && s2_acct_q && (s2_sz_addr_q == sz_raddr);
      gp_byp_q  <= s2_adv && s2_gcnt_q && (s2_gp_addr_q == gp_raddr);
    end else if (s2_adv) begin
      s2_vld_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_sz_addr_q <= sz_raddr;
      s2_gp_addr_q <= gp_raddr;
      s2_rd_gap_q  <= s1_item_q.rd_gap;
      s2_rd_ok_q   <= s1_item_q.rd_ok;
      sz_rok_q     <= sz_ok_q[sz_raddr];
      gp_rok_q     <= gp_ok_q[gp_raddr];
      sz_bdata_q   <= sz_new;
      gp_bdata_q   <= gp_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_acct_q) begin
      sz_mem[s2_sz_addr_q] <= sz_new;
    end
    if (s2_adv && s2_gcnt_q) begin
      gp_mem[s2_gp_addr_q] <= gp_new;
    end
    if (s1_adv) begin
      sz_rdata_q <= sz_mem[sz_raddr];
      gp_rdata_q <= gp_mem[gp_raddr];
    end
  end

  // An entry without its valid bit reads as zero; a new flow clears them all,
  // overriding a write-back of an older word on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sz_ok_q <= '0;
      gp_ok_q <= '0;
    end else if (s1_adv && s1_item_q.kind == flph_pkg::KindStart) begin
      sz_ok_q <= '0;
      gp_ok_q <= '0;
    end else begin
      if (s2_adv && s2_acct_q) begin
        sz_ok_q[s2_sz_addr_q] <= 1'b1;
      end
      if (s2_adv && s2_gcnt_q) begin
        gp_ok_q[s2_gp_addr_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (s2_kind_q == flph_pkg::KindStart) begin
      sz_base = '0;
      gp_base = '0;
    end else begin
      sz_base = sz_byp_q ? sz_bdata_q : (sz_rok_q ? sz_rdata_q : '0);
      gp_base = gp_byp_q ? gp_bdata_q : (gp_rok_q ? gp_rdata_q : '0);
    end
  end

  assign sz_new   = (&sz_base) ? sz_base : sz_base + COUNTER_BITS'(1);
  assign gp_new   = (&gp_base) ? gp_base : gp_base + COUNTER_BITS'(1);
  assign rd_val   = s2_rd_gap_q ? gp_base : sz_base;
  assign cnt_out  = (s2_kind_q == flph_pkg::KindRead && s2_rd_ok_q) ?
                    flph_pkg::OutCntW'(rd_val) : '0;
  assign sbin_out = s2_acct_q ? flph_pkg::OutBinW'(s2_sz_addr_q[BinW-1:0]) : '0;
  assign gbin_out = s2_gcnt_q ? flph_pkg::OutBinW'(s2_gp_addr_q[BinW-1:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s2_adv) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_data_q <= {cnt_out, gbin_out, s2_gcnt_q, sbin_out, s2_acct_q};
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

endmodule
